/* rtl/fnst_pkg.sv */
// Shared types, codes and defaults for the fixed-name symbol table.
package fnst_pkg;

  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_NAME_CHARS = 11;
  localparam int DEF_TYPE_BITS  = 8;

  // Names travel as 11 bytes: 64 low bits and 24 high bits.
  localparam int NAME_BYTES = 11;
  localparam int NAME_W     = 8 * NAME_BYTES;

  localparam logic [2:0] CMD_FIND     = 3'd0;
  localparam logic [2:0] CMD_DEFINE   = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_SET_TYPE = 3'd3;
  localparam logic [2:0] CMD_ROLLBACK = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RDWAIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    IDX_NONE,
    IDX_HIT,
    IDX_USED,
    IDX_POS
  } idx_sel_t;

  typedef struct packed {
    logic       load;
    logic       scan_en;
    logic       rd_pos;
    logic       wr_entry;
    logic       wr_type;
    logic       rollback;
    logic       clear;
    logic       resp;
    logic [2:0] resp_status;
    idx_sel_t   idx_sel;
    logic       data_sel;
    logic       unk_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       len_zero;
    logic       len_over;
    logic       pos_ok;
    logic       full;
    logic       hit;
    logic       scan_end;
  } dp_stat_t;

endpackage

/* rtl/fnst_ctrl.sv */
// Command sequencer for the symbol table: decode, scan and read control.
module fnst_ctrl import fnst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.cmd)
          CMD_FIND, CMD_DEFINE: begin
            if (!stat.len_zero && !stat.len_over) begin
              state_nxt = S_SCAN;
            end
          end
          CMD_READ: begin
            if (stat.pos_ok) begin
              state_nxt = S_RDWAIT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat.hit || stat.scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDWAIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.idx_sel = IDX_NONE;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_FIND: begin
            if (stat.len_zero || stat.len_over) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_NOT_FOUND;
            end
          end
          CMD_DEFINE: begin
            if (stat.len_zero) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_EMPTY;
            end else if (stat.len_over) begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_TOO_LONG;
            end
          end
          CMD_READ: begin
            if (stat.pos_ok) begin
              cmd.rd_pos = 1'b1;
            end else begin
              cmd.resp        = 1'b1;
              cmd.resp_status = ST_BAD_INDEX;
              cmd.unk_sel     = 1'b1;
            end
          end
          CMD_SET_TYPE: begin
            cmd.resp = 1'b1;
            if (stat.pos_ok) begin
              cmd.wr_type     = 1'b1;
              cmd.resp_status = ST_OK;
              cmd.idx_sel     = IDX_POS;
            end else begin
              cmd.resp_status = ST_BAD_INDEX;
            end
          end
          CMD_ROLLBACK: begin
            cmd.rollback    = 1'b1;
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_OK;
          end
          CMD_CLEAR: begin
            cmd.clear       = 1'b1;
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_OK;
          end
          default: begin
            cmd.resp        = 1'b1;
            cmd.resp_status = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.hit) begin
          cmd.resp = 1'b1;
          if (stat.cmd == CMD_FIND) begin
            cmd.resp_status = ST_OK;
            cmd.idx_sel     = IDX_HIT;
          end else begin
            cmd.resp_status = ST_DUPLICATE;
          end
        end else if (stat.scan_end) begin
          cmd.resp = 1'b1;
          if (stat.cmd == CMD_FIND) begin
            cmd.resp_status = ST_NOT_FOUND;
          end else if (stat.full) begin
            cmd.resp_status = ST_FULL;
          end else begin
            cmd.wr_entry    = 1'b1;
            cmd.resp_status = ST_OK;
            cmd.idx_sel     = IDX_USED;
          end
        end
      end
      S_RDWAIT: begin
        cmd.resp        = 1'b1;
        cmd.resp_status = ST_OK;
        cmd.idx_sel     = IDX_POS;
        cmd.data_sel    = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/fnst_dp.sv */
// Symbol table datapath: entry memories, scan compare, count and result words.
module fnst_dp import fnst_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int NAME_CHARS = DEF_NAME_CHARS,
  parameter int TYPE_BITS  = DEF_TYPE_BITS,
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_cmd,
  input  logic [63:0]       in_name_lo,
  input  logic [23:0]       in_name_hi,
  input  logic [3:0]        in_name_length,
  input  logic              in_let_flag,
  input  logic [7:0]        in_type_code,
  input  logic [7:0]        in_position,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [IDX_W-1:0]  out_result_index,
  output logic              out_let_out,
  output logic [7:0]        out_type_out,
  output logic [63:0]       out_name_lo_out,
  output logic [23:0]       out_name_hi_out,
  output logic [CNT_W-1:0]  out_entry_count
);

  localparam int TXW = (TYPE_BITS > 8) ? TYPE_BITS : 8;

  logic [NAME_W-1:0]    name_mem [ENTRIES];
  logic                 let_mem  [ENTRIES];
  logic [TYPE_BITS-1:0] type_mem [ENTRIES];

  logic [2:0]           cmd_r;
  logic [NAME_W-1:0]    key_r, care_r;
  logic [3:0]           len_r;
  logic                 let_r;
  logic [TYPE_BITS-1:0] typ_r;
  logic [7:0]           pos_r;
  logic [7:0]           unk_r;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [CNT_W-1:0]     addr_r;
  logic                 pv_r;
  logic [IDX_W-1:0]     pidx_r;
  logic [NAME_W-1:0]    rd_name_r;
  logic                 rd_let_r;
  logic [TYPE_BITS-1:0] rd_type_r;
  logic                 out_valid_r;

  logic [NAME_W-1:0]    in_name, key_nxt, care_nxt;
  logic [TXW-1:0]       typ_ext, rd_type_ext;
  logic                 scan_rd, rd_en, pos_ok, hit;
  logic [IDX_W-1:0]     rd_addr;

  assign in_name = {in_name_hi, in_name_lo};
  assign typ_ext = TXW'(in_type_code);

  // Key holds the input bytes below the length; the care mask also covers the
  // byte at the length, which a stored name must have as zero to match.
  always_comb begin
    for (int b = 0; b < NAME_BYTES; b++) begin
      key_nxt[8*b +: 8]  = (4'(b) < in_name_length) ? in_name[8*b +: 8] : 8'h00;
      care_nxt[8*b +: 8] = ((4'(b) <= in_name_length) && (b < NAME_CHARS)) ?
                           8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      key_r  <= key_nxt;
      care_r <= care_nxt;
      len_r  <= in_name_length;
      let_r  <= in_let_flag;
      typ_r  <= typ_ext[TYPE_BITS-1:0];
      pos_r  <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unk_r <= '0;
    end else if (cfg_we) begin
      unk_r <= cfg_wdata;
    end
  end

  assign scan_rd = cmd.scan_en && (addr_r != used_r);
  assign rd_en   = scan_rd || cmd.rd_pos;
  assign rd_addr = cmd.rd_pos ? pos_r[IDX_W-1:0] : addr_r[IDX_W-1:0];

  // The scan issues one read a cycle; pv_r marks that the read data register
  // holds entry pidx_r and is due for compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      pv_r   <= 1'b0;
    end else if (cmd.load) begin
      addr_r <= '0;
      pv_r   <= 1'b0;
    end else begin
      pv_r <= scan_rd;
      if (scan_rd) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      pidx_r <= addr_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_name_r <= name_mem[rd_addr];
      rd_let_r  <= let_mem[rd_addr];
      rd_type_r <= type_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      name_mem[used_r[IDX_W-1:0]] <= key_r;
      let_mem[used_r[IDX_W-1:0]]  <= let_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      type_mem[used_r[IDX_W-1:0]] <= typ_r;
    end else if (cmd.wr_type) begin
      type_mem[pos_r[IDX_W-1:0]] <= typ_r;
    end
  end

  assign pos_ok = (pos_r < 8'(used_r));
  assign hit    = pv_r && (((rd_name_r ^ key_r) & care_r) == '0);

  always_comb begin
    used_nxt = used_r;
    if (cmd.clear) begin
      used_nxt = '0;
    end else if (cmd.rollback && pos_ok) begin
      used_nxt = CNT_W'(pos_r);
    end else if (cmd.wr_entry) begin
      used_nxt = used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.len_zero = (len_r == 4'd0);
  assign stat.len_over = (len_r > 4'(NAME_CHARS));
  assign stat.pos_ok   = pos_ok;
  assign stat.full     = (used_r == CNT_W'(ENTRIES));
  assign stat.hit      = hit;
  assign stat.scan_end = (addr_r == used_r);

  assign rd_type_ext = TXW'(rd_type_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_status      <= cmd.resp_status;
      out_entry_count <= used_nxt;
      case (cmd.idx_sel)
        IDX_HIT:  out_result_index <= pidx_r;
        IDX_USED: out_result_index <= used_r[IDX_W-1:0];
        IDX_POS:  out_result_index <= pos_r[IDX_W-1:0];
        default:  out_result_index <= '0;
      endcase
      if (cmd.data_sel) begin
        out_let_out     <= rd_let_r;
        out_type_out    <= rd_type_ext[7:0];
        out_name_lo_out <= rd_name_r[63:0];
        out_name_hi_out <= rd_name_r[NAME_W-1:64];
      end else begin
        out_let_out     <= 1'b0;
        out_type_out    <= cmd.unk_sel ? unk_r : 8'h00;
        out_name_lo_out <= '0;
        out_name_hi_out <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/fixed_name_symbol_table_core.sv */
// Top level of the fixed-name symbol table: sequencer plus datapath.
//
// A command word is taken at a rising edge where start is high and busy is
// low. busy stays high until the command's result has been registered. Each
// command gives exactly one result word, shown on the out_ ports for one cycle
// with out_valid high; the receiver cannot stall, so it must take it then.
// Results for set type, rollback, clear, a refused find or define and a
// bad-index read are registered straight from the decode state; a read of a
// stored entry first waits in S_RDWAIT for the memory read; find and define
// scan the stored entries and may end early on a match.
// The find/define scan reads one stored name per cycle through the single
// read port of the entry memory and compares it against the registered key,
// so throughput is bounded by the entry count.
// A new command may be started in the cycle its result is shown.
// cfg_we writes the type code given by out-of-range reads; write it only
// while the block is idle. Synchronous reset empties the table and clears
// that register to zero; stored entries are not cleared and are never read
// before they are written.
module fixed_name_symbol_table_core import fnst_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int NAME_CHARS = DEF_NAME_CHARS,
  parameter int TYPE_BITS  = DEF_TYPE_BITS,
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_cmd,
  input  logic [63:0]      in_name_lo,
  input  logic [23:0]      in_name_hi,
  input  logic [3:0]       in_name_length,
  input  logic             in_let_flag,
  input  logic [7:0]       in_type_code,
  input  logic [7:0]       in_position,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [IDX_W-1:0] out_result_index,
  output logic             out_let_out,
  output logic [7:0]       out_type_out,
  output logic [63:0]      out_name_lo_out,
  output logic [23:0]      out_name_hi_out,
  output logic [CNT_W-1:0] out_entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fnst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fnst_dp #(
    .ENTRIES    (ENTRIES),
    .NAME_CHARS (NAME_CHARS),
    .TYPE_BITS  (TYPE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_name_lo       (in_name_lo),
    .in_name_hi       (in_name_hi),
    .in_name_length   (in_name_length),
    .in_let_flag      (in_let_flag),
    .in_type_code     (in_type_code),
    .in_position      (in_position),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_let_out      (out_let_out),
    .out_type_out     (out_type_out),
    .out_name_lo_out  (out_name_lo_out),
    .out_name_hi_out  (out_name_hi_out),
    .out_entry_count  (out_entry_count)
  );

endmodule
